>>> rtl/atr_pkg.sv
// Types, constants and helper functions for the smart card ATR parser.
`default_nettype none

package atr_pkg;

    localparam int MAX_PROTOCOLS = 7;
    localparam int MAX_ATR_BYTES = 63;

    localparam logic [7:0] INVERSE_MARK = 8'h03;
    localparam logic [7:0] TS_DIRECT    = 8'h3B;
    localparam logic [7:0] TS_INVERSE   = 8'h3F;
    localparam logic [7:0] IFSC_DEFAULT = 8'd32;
    localparam logic [7:0] WAIT_DEFAULT = 8'h4D;

    // Byte classification codes reported in byte_kind.
    localparam logic [3:0] KIND_TS   = 4'd0;
    localparam logic [3:0] KIND_T0   = 4'd1;
    localparam logic [3:0] KIND_TA   = 4'd2;
    localparam logic [3:0] KIND_TB   = 4'd3;
    localparam logic [3:0] KIND_TC   = 4'd4;
    localparam logic [3:0] KIND_TD   = 4'd5;
    localparam logic [3:0] KIND_HIST = 4'd6;
    localparam logic [3:0] KIND_TCK  = 4'd7;
    localparam logic [3:0] KIND_IGN  = 4'd8;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TCK   = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERR   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       is_last;
    } atr_in_t;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic [3:0] byte_kind;
        logic [2:0] group_index;
        logic       summary_valid;
        logic       status;
        logic [3:0] protocol_count;
        logic [3:0] hist_count;
        logic       tck_present;
        logic [7:0] ifsc;
        logic [7:0] bwi_cwi;
        logic [5:0] atr_length;
        logic       inverse_convention;
    } atr_out_t;

    // Inverse convention decoding: reverse the bit order and invert.
    function automatic logic [7:0] flip_bits(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = ~b[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/smartcard_atr_parser.sv
// Streaming ISO 7816-3 Answer-to-Reset parser, top level.
`default_nettype none

// One ATR byte is taken per request and one result comes back for each, with
// a summary on the result of the byte marked last. A new byte can be taken in
// every clock cycle while results are not stalled: a byte is held in an input
// register, classified by a single level of decision logic and written to a
// result register. The input register and the result register each hold one
// request, so one more byte is accepted while a result waits to be taken.
// After the last byte the parser returns to its reset state and expects the
// TS of a new ATR.
module smartcard_atr_parser (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               byte_valid,
    output logic              byte_stall,
    input  atr_pkg::atr_in_t  byte_data,
    output logic              res_valid,
    input  wire               res_stall,
    output atr_pkg::atr_out_t res_data
);
    import atr_pkg::*;

    localparam logic [5:0] ATR_LIMIT  = 6'(MAX_ATR_BYTES);
    localparam logic [2:0] GROUP_LIMIT = 3'(MAX_PROTOCOLS);

    // Input register
    logic    in_valid_reg;
    atr_in_t in_item_reg;

    // Result register
    logic     out_valid_reg;
    atr_out_t out_item_reg;

    // Parser state
    phase_t     phase_reg, phase_next;
    logic [5:0] byte_count_reg, byte_count_next;
    logic [2:0] group_reg, group_next;
    logic [3:0] pending_reg, pending_next;
    logic [3:0] hist_rem_reg, hist_rem_next;
    logic [3:0] hist_total_reg, hist_total_next;
    logic       check_reg, check_next;
    logic       invert_reg, invert_next;
    logic       t1_seen_reg, t1_seen_next;
    logic [2:0] t1_group_reg, t1_group_next;
    logic [7:0] ifsc_reg, ifsc_next;
    logic [7:0] wait_reg, wait_next;
    logic       error_reg, error_next;
    logic [5:0] length_reg, length_next;

    logic       advance;
    logic       in_range;
    logic [7:0] dec;
    logic [3:0] kind;
    logic [2:0] grp;
    logic       end_iface;
    atr_out_t   result;

    assign advance    = in_valid_reg && (!out_valid_reg || !res_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_item_reg;

    assign in_range    = byte_count_reg < ATR_LIMIT;
    assign invert_next = (byte_count_reg == '0) ? (in_item_reg.raw_byte == INVERSE_MARK)
                                                : invert_reg;
    assign dec = invert_next ? flip_bits(in_item_reg.raw_byte) : in_item_reg.raw_byte;

    // Classification of the current byte.
    always_comb
    begin
        kind = KIND_IGN;
        grp  = '0;
        if (in_range) begin
            unique case (phase_reg)
                PH_TS:    kind = KIND_TS;
                PH_T0:    kind = KIND_T0;
                PH_IFACE:
                begin
                    grp = group_reg;
                    if (pending_reg[0]) begin
                        kind = KIND_TA;
                    end else if (pending_reg[1]) begin
                        kind = KIND_TB;
                    end else if (pending_reg[2]) begin
                        kind = KIND_TC;
                    end else begin
                        kind = KIND_TD;
                    end
                end
                PH_HIST:  kind = KIND_HIST;
                PH_TCK:   kind = KIND_TCK;
                default:  kind = KIND_IGN;
            endcase
        end
    end

    // Next parser state.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        group_next      = group_reg;
        pending_next    = pending_reg;
        hist_rem_next   = hist_rem_reg;
        hist_total_next = hist_total_reg;
        check_next      = check_reg;
        t1_seen_next    = t1_seen_reg;
        t1_group_next   = t1_group_reg;
        ifsc_next       = ifsc_reg;
        wait_next       = wait_reg;
        error_next      = error_reg;
        length_next     = length_reg;
        end_iface       = 1'b0;

        if (in_range) begin
            byte_count_next = byte_count_reg + 6'd1;
            unique case (phase_reg)
                PH_TS:
                begin
                    if (dec == TS_DIRECT || dec == TS_INVERSE) begin
                        phase_next = PH_T0;
                    end else begin
                        phase_next = PH_ERR;
                        error_next = 1'b1;
                    end
                end
                PH_T0:
                begin
                    hist_total_next = dec[3:0];
                    pending_next    = dec[7:4];
                    group_next      = '0;
                    check_next      = 1'b0;
                    phase_next      = PH_IFACE;
                    end_iface       = (dec[7:4] == '0);
                end
                PH_IFACE:
                begin
                    case (kind)
                        KIND_TA:
                        begin
                            pending_next[0] = 1'b0;
                            if (t1_seen_reg && group_reg == t1_group_reg) begin
                                ifsc_next = dec;
                            end
                        end
                        KIND_TB:
                        begin
                            pending_next[1] = 1'b0;
                            if (t1_seen_reg && group_reg == t1_group_reg) begin
                                wait_next = dec;
                            end
                        end
                        KIND_TC:
                        begin
                            pending_next[2] = 1'b0;
                        end
                        default:
                        begin
                            check_next = (dec[3:0] != '0);
                            if (group_reg >= GROUP_LIMIT) begin
                                error_next   = 1'b1;
                                phase_next   = PH_ERR;
                                pending_next = '0;
                            end else begin
                                // The first T=1 indication from TD2 on selects the
                                // group that carries IFSC and BWI/CWI.
                                if (!t1_seen_reg && group_reg != '0 && dec[3:0] == 4'd1) begin
                                    t1_seen_next  = 1'b1;
                                    t1_group_next = group_reg + 3'd1;
                                end
                                group_next   = group_reg + 3'd1;
                                pending_next = dec[7:4];
                            end
                        end
                    endcase
                    end_iface = (pending_next == '0) && (phase_next != PH_ERR);
                end
                PH_HIST:
                begin
                    hist_rem_next = hist_rem_reg - 4'd1;
                    if (hist_rem_next == '0) begin
                        if (check_reg) begin
                            phase_next = PH_TCK;
                        end else begin
                            phase_next  = PH_DONE;
                            length_next = byte_count_reg + 6'd1;
                        end
                    end
                end
                PH_TCK:
                begin
                    phase_next  = PH_DONE;
                    length_next = byte_count_reg + 6'd1;
                end
                default:
                begin
                end
            endcase

            if (end_iface) begin
                hist_rem_next = hist_total_next;
                if (hist_total_next != '0) begin
                    phase_next = PH_HIST;
                end else if (check_next) begin
                    phase_next = PH_TCK;
                end else begin
                    phase_next  = PH_DONE;
                    length_next = byte_count_reg + 6'd1;
                end
            end
        end
    end

    // Result assembly; the summary reflects the state after this byte.
    always_comb
    begin
        result              = '0;
        result.decoded_byte = dec;
        result.byte_kind    = kind;
        result.group_index  = grp;
        if (in_item_reg.is_last) begin
            result.summary_valid      = 1'b1;
            result.status             = error_next || (phase_next != PH_DONE);
            result.protocol_count     = {1'b0, group_next} + 4'd1;
            result.hist_count         = hist_total_next;
            result.tck_present        = check_next;
            result.ifsc               = ifsc_next;
            result.bwi_cwi            = wait_next;
            result.atr_length         = (phase_next == PH_DONE && !error_next) ? length_next
                                                                                : '0;
            result.inverse_convention = invert_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (!byte_stall) begin
                in_valid_reg <= byte_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (!res_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            in_item_reg <= byte_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_TS;
            byte_count_reg <= '0;
            group_reg      <= '0;
            pending_reg    <= '0;
            hist_rem_reg   <= '0;
            hist_total_reg <= '0;
            check_reg      <= 1'b0;
            invert_reg     <= 1'b0;
            t1_seen_reg    <= 1'b0;
            t1_group_reg   <= '0;
            ifsc_reg       <= IFSC_DEFAULT;
            wait_reg       <= WAIT_DEFAULT;
            error_reg      <= 1'b0;
            length_reg     <= '0;
        end else if (advance) begin
            if (in_item_reg.is_last) begin
                // The last byte closes the ATR: start over for the next one.
                phase_reg      <= PH_TS;
                byte_count_reg <= '0;
                group_reg      <= '0;
                pending_reg    <= '0;
                hist_rem_reg   <= '0;
                hist_total_reg <= '0;
                check_reg      <= 1'b0;
                invert_reg     <= 1'b0;
                t1_seen_reg    <= 1'b0;
                t1_group_reg   <= '0;
                ifsc_reg       <= IFSC_DEFAULT;
                wait_reg       <= WAIT_DEFAULT;
                error_reg      <= 1'b0;
                length_reg     <= '0;
            end else begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                group_reg      <= group_next;
                pending_reg    <= pending_next;
                hist_rem_reg   <= hist_rem_next;
                hist_total_reg <= hist_total_next;
                check_reg      <= check_next;
                invert_reg     <= invert_next;
                t1_seen_reg    <= t1_seen_next;
                t1_group_reg   <= t1_group_next;
                ifsc_reg       <= ifsc_next;
                wait_reg       <= wait_next;
                error_reg      <= error_next;
                length_reg     <= length_next;
            end
        end
    end

endmodule

`default_nettype wire
